// ----- hw/rtl/anim_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// Animation RLE frame decoder package
// Shared types and constants of the byte-run and line-delta chunk decoder:
// register indexes, parser phase codes and the result beat layout.
// ----------------------------------------------------------------------------
package anim_rle_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_PITCH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER   = 3'd4;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_RPKT  = 4'd1;
  localparam logic [3:0] PH_RSIZE = 4'd2;
  localparam logic [3:0] PH_RLIT  = 4'd3;
  localparam logic [3:0] PH_RREP  = 4'd4;
  localparam logic [3:0] PH_DH0   = 4'd5;
  localparam logic [3:0] PH_DH1   = 4'd6;
  localparam logic [3:0] PH_DH2   = 4'd7;
  localparam logic [3:0] PH_DH3   = 4'd8;
  localparam logic [3:0] PH_DPKT  = 4'd9;
  localparam logic [3:0] PH_DSKIP = 4'd10;
  localparam logic [3:0] PH_DSIZE = 4'd11;
  localparam logic [3:0] PH_DLIT  = 4'd12;
  localparam logic [3:0] PH_DREP  = 4'd13;

  typedef struct packed {
    logic [19:0] span_address;
    logic [7:0]  span_length;
    logic [7:0]  pixel_value;
    logic        chunk_done;
    logic        address_overflow;
  } span_t;

endpackage

// ----- hw/rtl/animation_rle_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Animation RLE frame decoder core
// Parses one byte-run or line-delta animation chunk, one payload byte per
// beat, and emits at most one framebuffer span per byte.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | data_byte, chunk_start
//  output   | out_valid / out_stall| span_address, span_length, pixel_value,
//           |                      | chunk_done, address_overflow
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input beat is taken per cycle while in_stall is low; its span is registered.
// The next parser state and the result are computed combinationally; the longest
// path is the header word times line pitch product and its saturation.
// A two-entry output buffer absorbs one result while the output is stalled;
// in_stall rises only when the spare entry is full.
// Reset (rst, synchronous) empties the buffer and puts the parser in idle.
// ----------------------------------------------------------------------------
module animation_rle_frame_decoder_core
  import anim_rle_pkg::*;
#(
  parameter int ADDR_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   chunk_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [19:0]            span_address,
  output logic [7:0]             span_length,
  output logic [7:0]             pixel_value,
  output logic                   chunk_done,
  output logic                   address_overflow,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = ADDR_BITS + 1;
  localparam int MW = (AW > 29) ? AW : 29;
  localparam logic [AW-1:0] LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

  logic        decode_mode;
  logic [12:0] line_pitch;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        byte_order;

  logic [3:0]    phase, phase_next;
  logic [15:0]   lines_left, lines_left_next;
  logic [7:0]    packets_left, packets_left_next;
  logic [7:0]    run_left, run_left_next;
  logic [AW-1:0] write_address, write_address_next;
  logic [AW-1:0] line_start_address, line_start_address_next;
  logic [7:0]    header_low_byte, header_low_byte_next;

  logic [3:0]    ph;
  logic [15:0]   lines_c;
  logic [7:0]    pk_c, run_c, hlb_c;
  logic [AW-1:0] wa_c, ls_c;
  logic          empty_chunk, is_delta, litrep, lit;
  logic [7:0]    len_e;
  logic [AW-1:0] sum_wl, wa_adv, skip_sum, skip_sat;
  logic          ovf_e;
  logic [AW:0]   t_raw, d_run, ls_raw;
  logic [AW-1:0] t_sat, run_end_addr, delta_end_addr;
  logic [15:0]   hdr_word;
  logic [28:0]   prod;
  logic [MW-1:0] prod_ext;
  logic [AW-1:0] prod_sat;

  logic          emit, done, ovf, pkt_done, line_end;
  logic [7:0]    len, val;
  logic [AW-1:0] addr_o;
  logic [AW+19:0] addr_ext;
  span_t         res;

  logic  accept, take, out_load_new, out_load_skid, skid_load, skid_valid;
  span_t out_reg, skid_reg;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;

  // Chunk start drops the parser state and enters the first phase.
  assign ph          = chunk_start ? (decode_mode ? PH_DH0 : PH_RPKT) : phase;
  assign lines_c     = chunk_start ? (decode_mode ? 16'd0 : {3'd0, image_height})
                                   : lines_left;
  assign pk_c        = chunk_start ? 8'd0 : packets_left;
  assign run_c       = chunk_start ? 8'd0 : run_left;
  assign hlb_c       = chunk_start ? 8'd0 : header_low_byte;
  assign wa_c        = chunk_start ? '0 : write_address;
  assign ls_c        = chunk_start ? '0 : line_start_address;
  assign empty_chunk = chunk_start && !decode_mode && (image_height == 13'd0);

  assign is_delta = (ph >= PH_DH0);
  assign lit      = (ph == PH_RLIT) || (ph == PH_DLIT);
  assign litrep   = lit || (ph == PH_RREP) || (ph == PH_DREP);
  assign len_e    = lit ? 8'd1 : run_c;
  assign sum_wl   = wa_c + AW'(len_e);
  assign ovf_e    = sum_wl > LIMIT;
  assign wa_adv   = ovf_e ? LIMIT : sum_wl;

  assign skip_sum = wa_c + AW'(data_byte);
  assign skip_sat = (skip_sum > LIMIT) ? LIMIT : skip_sum;

  // Run-mode line end: saturated address plus pitch, minus width, floored at 0.
  assign t_raw = (AW+1)'(wa_c) + (AW+1)'(litrep ? len_e : 8'd0) + (AW+1)'(line_pitch);
  assign t_sat = (t_raw > (AW+1)'(LIMIT)) ? LIMIT : t_raw[AW-1:0];
  assign d_run = {1'b0, t_sat} - (AW+1)'(image_width);
  assign run_end_addr = d_run[AW] ? '0 : d_run[AW-1:0];

  assign ls_raw         = (AW+1)'(ls_c) + (AW+1)'(line_pitch);
  assign delta_end_addr = (ls_raw > (AW+1)'(LIMIT)) ? LIMIT : ls_raw[AW-1:0];

  assign hdr_word = byte_order ? {hlb_c, data_byte} : {data_byte, hlb_c};
  assign prod     = 29'(hdr_word) * 29'(line_pitch);
  assign prod_ext = MW'(prod);
  assign prod_sat = (prod_ext > MW'(LIMIT)) ? LIMIT : prod_ext[AW-1:0];

  always_comb begin
    phase_next              = ph;
    lines_left_next         = lines_c;
    packets_left_next       = pk_c;
    run_left_next           = run_c;
    write_address_next      = wa_c;
    line_start_address_next = ls_c;
    header_low_byte_next    = hlb_c;
    emit     = 1'b0;
    done     = 1'b0;
    ovf      = 1'b0;
    len      = 8'd0;
    val      = 8'd0;
    addr_o   = wa_c;
    pkt_done = 1'b0;
    line_end = 1'b0;

    if (empty_chunk) begin
      phase_next = PH_IDLE;
      done       = 1'b1;
    end else begin
      unique case (ph) inside
        PH_RPKT, PH_DPKT: begin
          packets_left_next = data_byte;
          if (data_byte == 8'd0) begin
            line_end = 1'b1;
          end else begin
            phase_next = is_delta ? PH_DSKIP : PH_RSIZE;
          end
        end
        PH_RSIZE: begin
          if (data_byte[7]) begin
            run_left_next = 8'd0 - data_byte;
            phase_next    = PH_RLIT;
          end else if (data_byte != 8'd0) begin
            run_left_next = data_byte;
            phase_next    = PH_RREP;
          end else begin
            pkt_done = 1'b1;
          end
        end
        PH_DSKIP: begin
          write_address_next = skip_sat;
          phase_next         = PH_DSIZE;
        end
        PH_DSIZE: begin
          if (data_byte[7]) begin
            run_left_next = 8'd0 - data_byte;
            phase_next    = PH_DREP;
          end else if (data_byte != 8'd0) begin
            run_left_next = data_byte;
            phase_next    = PH_DLIT;
          end else begin
            pkt_done = 1'b1;
          end
        end
        PH_RLIT, PH_DLIT, PH_RREP, PH_DREP: begin
          emit               = 1'b1;
          len                = len_e;
          val                = data_byte;
          ovf                = ovf_e;
          write_address_next = wa_adv;
          run_left_next      = lit ? (run_c - 8'd1) : 8'd0;
          if (!lit || (run_c == 8'd1)) begin
            pkt_done = 1'b1;
          end
        end
        PH_DH0, PH_DH2: begin
          header_low_byte_next = data_byte;
          phase_next           = ph + 4'd1;
        end
        PH_DH1: begin
          line_start_address_next = prod_sat;
          write_address_next      = prod_sat;
          phase_next              = PH_DH2;
        end
        PH_DH3: begin
          lines_left_next = hdr_word;
          if (hdr_word == 16'd0) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            phase_next = PH_DPKT;
          end
        end
        default: begin
        end
      endcase

      if (pkt_done) begin
        packets_left_next = pk_c - 8'd1;
        if (pk_c == 8'd1) begin
          line_end = 1'b1;
        end else begin
          phase_next = is_delta ? PH_DSKIP : PH_RSIZE;
        end
      end

      if (line_end) begin
        if (is_delta) begin
          line_start_address_next = delta_end_addr;
          write_address_next      = delta_end_addr;
        end else begin
          line_start_address_next = run_end_addr;
          write_address_next      = run_end_addr;
        end
        lines_left_next = lines_c - 16'd1;
        if (lines_c == 16'd1) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end else begin
          phase_next = is_delta ? PH_DPKT : PH_RPKT;
        end
      end
    end

    if (done) begin
      emit = 1'b1;
      if (len == 8'd0) begin
        addr_o = write_address_next;
      end
    end
  end

  assign addr_ext = (AW+20)'(addr_o);

  always_comb begin
    res.span_address     = addr_ext[19:0];
    res.span_length      = ovf ? 8'd0 : len;
    res.pixel_value      = val;
    res.chunk_done       = done;
    res.address_overflow = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= 1'b0;
      line_pitch   <= 13'd320;
      image_width  <= 13'd320;
      image_height <= 13'd200;
      byte_order   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECODE_MODE:  decode_mode  <= cfg_data[0];
        REG_LINE_PITCH:   line_pitch   <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_BYTE_ORDER:   byte_order   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      lines_left         <= 16'd0;
      packets_left       <= 8'd0;
      run_left           <= 8'd0;
      write_address      <= '0;
      line_start_address <= '0;
      header_low_byte    <= 8'd0;
    end else if (accept) begin
      phase              <= phase_next;
      lines_left         <= lines_left_next;
      packets_left       <= packets_left_next;
      run_left           <= run_left_next;
      write_address      <= write_address_next;
      line_start_address <= line_start_address_next;
      header_low_byte    <= header_low_byte_next;
    end
  end

  // The spare entry is filled only when the output register holds a stalled beat.
  assign take          = out_valid && !out_stall;
  assign out_load_skid = (take || !out_valid) && skid_valid;
  assign out_load_new  = (take || !out_valid) && !skid_valid && accept && emit;
  assign skid_load     = out_valid && !take && accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_load_skid || out_load_new) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      if (out_load_skid) begin
        skid_valid <= 1'b0;
      end else if (skid_load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_skid) begin
      out_reg <= skid_reg;
    end else if (out_load_new) begin
      out_reg <= res;
    end
    if (skid_load) begin
      skid_reg <= res;
    end
  end

  assign span_address     = out_reg.span_address;
  assign span_length      = out_reg.span_length;
  assign pixel_value      = out_reg.pixel_value;
  assign chunk_done       = out_reg.chunk_done;
  assign address_overflow = out_reg.address_overflow;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("spare entry full while output register is empty");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> out_valid)
    else $error("accepted span did not reach the output");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> (phase == PH_IDLE))
    else $error("parser not idle after chunk end");

  a_addr_saturated: assert property (@(posedge clk) disable iff (rst)
    (write_address <= LIMIT) && (line_start_address <= LIMIT))
    else $error("address register beyond memory limit");

  a_lines_in_body: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RPKT || phase == PH_RSIZE || phase == PH_RLIT || phase == PH_RREP ||
     phase == PH_DPKT || phase == PH_DSKIP || phase == PH_DSIZE ||
     phase == PH_DLIT || phase == PH_DREP) |-> (lines_left != 16'd0))
    else $error("line body parsed with no lines left");
`endif

endmodule

// ----- test/animation_rle_frame_decoder_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Animation RLE frame decoder core testbench
// Streams byte-run and line-delta chunks through the decoder with random
// bursts and output stalls. A span predictor mirrors the parser and the
// register file, and every span beat is compared field by field against it.
// ----------------------------------------------------------------------------
module animation_rle_frame_decoder_core_test
  import anim_rle_pkg::*;
();

  class span_predictor_t;
    localparam logic [32:0] MemLimit = 33'h10_0000;

    logic        decode_mode;
    logic [12:0] line_pitch;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        byte_order;

    logic [3:0]  phase;
    logic [15:0] lines_left;
    logic [7:0]  packets_left;
    logic [7:0]  run_left;
    logic [20:0] wr_addr;
    logic [20:0] line_addr;
    logic [7:0]  hdr_low;

    span_t pending_spans[$];
    int    errors;

    function new();
      decode_mode  = 1'b0;
      line_pitch   = 13'd320;
      image_width  = 13'd320;
      image_height = 13'd200;
      byte_order   = 1'b0;
      phase        = PH_IDLE;
      lines_left   = '0;
      packets_left = '0;
      run_left     = '0;
      wr_addr      = '0;
      line_addr    = '0;
      hdr_low      = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DECODE_MODE:  decode_mode  = val[0];
        REG_LINE_PITCH:   line_pitch   = val;
        REG_IMAGE_WIDTH:  image_width  = val;
        REG_IMAGE_HEIGHT: image_height = val;
        REG_BYTE_ORDER:   byte_order   = val[0];
        default: ;
      endcase
    endfunction

    function logic [20:0] sat_add(logic [20:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {12'd0, a} + {1'b0, b};
      if (s > MemLimit) s = MemLimit;
      return s[20:0];
    endfunction

    function bit line_end();
      logic [20:0] t;
      if (phase >= PH_DH0) begin
        line_addr = sat_add(line_addr, {19'd0, line_pitch});
        wr_addr = line_addr;
      end else begin
        t = sat_add(wr_addr, {19'd0, line_pitch});
        wr_addr = (t >= {8'd0, image_width}) ? t - {8'd0, image_width} : 21'd0;
        line_addr = wr_addr;
      end
      lines_left = lines_left - 16'd1;
      if (lines_left == 16'd0) begin
        phase = PH_IDLE;
        return 1'b1;
      end
      phase = (phase >= PH_DH0) ? PH_DPKT : PH_RPKT;
      return 1'b0;
    endfunction

    function bit packet_end();
      packets_left = packets_left - 8'd1;
      if (packets_left == 8'd0) return line_end();
      phase = (phase >= PH_DH0) ? PH_DSKIP : PH_RSIZE;
      return 1'b0;
    endfunction

    function bit packets_begin(logic [7:0] b);
      packets_left = b;
      if (b == 8'd0) return line_end();
      phase = (phase >= PH_DH0) ? PH_DSKIP : PH_RSIZE;
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      bit          emit;
      bit          done;
      bit          ovf;
      bit          lit;
      logic [7:0]  len;
      logic [7:0]  val;
      logic [20:0] addr;
      logic [15:0] w;
      span_t       s;
      emit = 1'b0;
      done = 1'b0;
      ovf  = 1'b0;
      len  = '0;
      val  = '0;
      if (start) begin
        wr_addr      = '0;
        line_addr    = '0;
        packets_left = '0;
        run_left     = '0;
        hdr_low      = '0;
        if (decode_mode) begin
          lines_left = '0;
          phase = PH_DH0;
        end else begin
          lines_left = {3'd0, image_height};
          phase = PH_RPKT;
          if (lines_left == 16'd0) begin
            phase = PH_IDLE;
            done = 1'b1;
          end
        end
      end
      addr = wr_addr;
      if (!done) begin
        case (phase)
          PH_RPKT, PH_DPKT: done = packets_begin(b);
          PH_RSIZE: begin
            if (b[7]) begin
              run_left = 8'd0 - b;
              phase = PH_RLIT;
            end else if (b != 8'd0) begin
              run_left = b;
              phase = PH_RREP;
            end else begin
              done = packet_end();
            end
          end
          PH_DSKIP: begin
            wr_addr = sat_add(wr_addr, {24'd0, b});
            phase = PH_DSIZE;
          end
          PH_DSIZE: begin
            if (b[7]) begin
              run_left = 8'd0 - b;
              phase = PH_DREP;
            end else if (b != 8'd0) begin
              run_left = b;
              phase = PH_DLIT;
            end else begin
              done = packet_end();
            end
          end
          PH_RLIT, PH_DLIT, PH_RREP, PH_DREP: begin
            lit = (phase == PH_RLIT) || (phase == PH_DLIT);
            len = lit ? 8'd1 : run_left;
            val = b;
            addr = wr_addr;
            emit = 1'b1;
            ovf = ({12'd0, wr_addr} + {25'd0, len}) > MemLimit;
            wr_addr = sat_add(wr_addr, {24'd0, len});
            run_left = lit ? run_left - 8'd1 : 8'd0;
            if (run_left == 8'd0) done = packet_end();
          end
          PH_DH0, PH_DH2: begin
            hdr_low = b;
            phase = phase + 4'd1;
          end
          PH_DH1, PH_DH3: begin
            w = byte_order ? {hdr_low, b} : {b, hdr_low};
            if (phase == PH_DH1) begin
              line_addr = sat_add(21'd0, {16'd0, w} * {19'd0, line_pitch});
              wr_addr = line_addr;
              phase = PH_DH2;
            end else begin
              lines_left = w;
              if (w == 16'd0) begin
                phase = PH_IDLE;
                done = 1'b1;
              end else begin
                phase = PH_DPKT;
              end
            end
          end
          default: ;
        endcase
      end
      if (done) begin
        emit = 1'b1;
        if (len == 8'd0) addr = wr_addr;
      end
      if (emit) begin
        s.span_address     = addr[19:0];
        s.span_length      = ovf ? 8'd0 : len;
        s.pixel_value      = val;
        s.chunk_done       = done;
        s.address_overflow = ovf;
        pending_spans.push_back(s);
      end
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [19:0] got, logic [19:0] want);
      if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_span(span_t got);
      span_t want;
      if (pending_spans.size() == 0) begin
        report($sformatf("span beat at address %h with nothing expected", got.span_address));
      end else begin
        want = pending_spans.pop_front();
        compare_field("span_address", got.span_address, want.span_address);
        compare_field("span_length", {12'd0, got.span_length}, {12'd0, want.span_length});
        compare_field("pixel_value", {12'd0, got.pixel_value}, {12'd0, want.pixel_value});
        compare_field("chunk_done", {19'd0, got.chunk_done}, {19'd0, want.chunk_done});
        compare_field("address_overflow", {19'd0, got.address_overflow},
                      {19'd0, want.address_overflow});
      end
    endtask

    task flush_leftovers();
      span_t s;
      while (pending_spans.size() != 0) begin
        s = pending_spans.pop_front();
        report($sformatf("span at address %h never arrived", s.span_address));
      end
    endtask
  endclass

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } chunk_beat_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             data_byte;
  logic                   chunk_start;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [19:0]            span_address;
  logic [7:0]             span_length;
  logic [7:0]             pixel_value;
  logic                   chunk_done;
  logic                   address_overflow;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  span_predictor_t sb;
  chunk_beat_t     chunk_beats[$];
  int              burst_left = 0;
  int              random_items = 0;
  stall_mode_t     stall_mode = STALL_NONE;
  int              pattern_left = 0;
  int              stall_period = 2;
  int              stall_tick = 0;

  animation_rle_frame_decoder_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .chunk_start      (chunk_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .span_address     (span_address),
    .span_length      (span_length),
    .pixel_value      (pixel_value),
    .chunk_done       (chunk_done),
    .address_overflow (address_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (pattern_left == 0) begin
      stall_mode   = stall_mode_t'($urandom_range(0, 3));
      pattern_left = $urandom_range(32, 256);
      stall_period = $urandom_range(2, 8);
    end
    pattern_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = ((stall_tick % stall_period) < (stall_period / 2));
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_span('{span_address, span_length, pixel_value, chunk_done, address_overflow});
    end
  end

  task send_item(logic [7:0] b, logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid    = 1'b1;
    data_byte   = b;
    chunk_start = start;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, start);
    burst_left--;
  endtask

  task settle();
    int waited;
    @(negedge clk);
    in_valid = 1'b0;
    for (waited = 0; waited < 4000 && sb.pending_spans.size() != 0; waited++) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task apply_config(int mode, int pitch, int width, int height, int order);
    settle();
    cfg_write(REG_DECODE_MODE, CFG_DATA_W'(mode));
    cfg_write(REG_LINE_PITCH, CFG_DATA_W'(pitch));
    cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
    cfg_write(REG_BYTE_ORDER, CFG_DATA_W'(order));
  endtask

  function void push_beat(int b);
    chunk_beats.push_back('{8'(b), chunk_beats.size() == 0});
  endfunction

  function void push_word(int w);
    if (sb.byte_order) begin
      push_beat((w >> 8) & 8'hFF);
      push_beat(w & 8'hFF);
    end else begin
      push_beat(w & 8'hFF);
      push_beat((w >> 8) & 8'hFF);
    end
  endfunction

  function void build_run_chunk(int line_cap, int empty_pct);
    int lines;
    int npk;
    int kind;
    int n;
    lines = (sb.image_height < line_cap) ? sb.image_height : line_cap;
    if (lines == 0) push_beat($urandom_range(0, 255));
    for (int l = 0; l < lines; l++) begin
      npk = ($urandom_range(0, 99) < empty_pct) ? 0 : $urandom_range(1, 3);
      push_beat(npk);
      for (int p = 0; p < npk; p++) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          n = ($urandom_range(0, 29) == 0) ? 128 : $urandom_range(1, 3);
          push_beat(256 - n);
          repeat (n) push_beat($urandom_range(0, 255));
        end else if (kind < 9) begin
          push_beat($urandom_range(1, 127));
          push_beat($urandom_range(0, 255));
        end else begin
          push_beat(0);
        end
      end
    end
  endfunction

  function void build_delta_chunk();
    int count;
    int npk;
    int kind;
    int n;
    push_word(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3));
    count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    push_word(count);
    for (int l = 0; l < count; l++) begin
      npk = $urandom_range(0, 3);
      push_beat(npk);
      for (int p = 0; p < npk; p++) begin
        push_beat($urandom_range(0, 255));
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          n = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 3);
          push_beat(n);
          repeat (n) push_beat($urandom_range(0, 255));
        end else if (kind < 9) begin
          push_beat(256 - $urandom_range(1, 128));
          push_beat($urandom_range(0, 255));
        end else begin
          push_beat(0);
        end
      end
    end
  endfunction

  task run_phase(int mode, int pitch, int width, int height, int order,
                 int line_cap, int empty_pct, int budget);
    int sent;
    int keep;
    apply_config(mode, pitch, width, height, order);
    sent = 0;
    while (sent < budget) begin
      chunk_beats.delete();
      if (sb.decode_mode) build_delta_chunk();
      else build_run_chunk(line_cap, empty_pct);
      if ($urandom_range(0, 99) < 15 && chunk_beats.size() > 1) begin
        keep = $urandom_range(1, chunk_beats.size() - 1);
        while (chunk_beats.size() > keep) void'(chunk_beats.pop_back());
      end
      sent += chunk_beats.size();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_beat($urandom_range(0, 255));
      foreach (chunk_beats[i]) send_item(chunk_beats[i].data, chunk_beats[i].start);
    end
    random_items += sent;
  endtask

  initial begin
    int pitch;
    int width;
    int height;
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    chunk_start = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_item(8'hFF, 1'b0);
    apply_config(0, 8, 4, 0, 0);
    send_item(8'h00, 1'b1);
    apply_config(0, 8, 4, 2, 0);
    send_item(8'h03, 1'b1);
    send_item(8'hFE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h33, 1'b0);
    apply_config(1, 4096, 4, 0, 1);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h77, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    apply_config(1, 1, 1, 1, 0);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h10, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b0);

    run_phase(0, 1, 4096, 4096, 0, 6, 20, 100);
    run_phase(0, 4096, 1, 300, 1, 300, 90, 1);
    while (random_items < 1350) begin
      case ($urandom_range(0, 3))
        0:       pitch = 1;
        1:       pitch = 4096;
        2:       pitch = $urandom_range(1, 4096);
        default: pitch = $urandom_range(8, 512);
      endcase
      case ($urandom_range(0, 3))
        0:       width = 1;
        1:       width = 4096;
        2:       width = $urandom_range(1, 4096);
        default: width = $urandom_range(1, pitch);
      endcase
      case ($urandom_range(0, 9))
        0:       height = 0;
        1:       height = 4096;
        default: height = $urandom_range(1, 6);
      endcase
      run_phase($urandom_range(0, 1), pitch, width, height, $urandom_range(0, 1), 6, 20, 110);
    end

    settle();
    sb.flush_leftovers();
    if (sb.errors == 0) $display("animation_rle_frame_decoder_core_test passed");
    else $display("animation_rle_frame_decoder_core_test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("animation_rle_frame_decoder_core_test failed");
    $finish;
  end

endmodule
